// File: design/lrpt_pkg.sv
`timescale 1ns / 1ps

package lrpt_pkg;

    // request codes carried in s_tuser
    localparam logic [2:0] REQ_START  = 3'd0;
    localparam logic [2:0] REQ_STOP   = 3'd1;
    localparam logic [2:0] REQ_PAUSE  = 3'd2;
    localparam logic [2:0] REQ_RESUME = 3'd3;
    localparam logic [2:0] REQ_RESET  = 3'd4;
    localparam logic [2:0] REQ_TICK   = 3'd5;

    // run modes
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_RUN   = 2'd1;
    localparam logic [1:0] MODE_PAUSE = 2'd2;
    localparam logic [1:0] MODE_DONE  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_DURATION = 2'd0;
    localparam logic [1:0] CFG_DELAY    = 2'd1;
    localparam logic [1:0] CFG_LOOPS    = 2'd2;
    localparam logic [1:0] CFG_PINGPONG = 2'd3;

    localparam int          LOOP_W      = 16;
    localparam int          LIMIT_W     = 17;
    localparam int          DELTA_W     = 16;
    localparam logic [15:0] LOOP_MAX    = 16'hFFFF;
    localparam logic [31:0] DURATION_RST = 32'd1000000;

    // shared unit operation
    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    typedef struct packed {
        logic loop_ended;
        logic completed;
        logic started;
    } evt_flags_t;

endpackage

// File: design/lrpt_alu.sv
`timescale 1ns / 1ps

module lrpt_alu #(
    parameter int WIDTH = 27
) (
    input  logic             op,
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic [WIDTH-1:0] res,
    output logic             ge
);

    logic [WIDTH:0] full;

    always_comb begin
        if (op == lrpt_pkg::ALU_SUB) begin
            full = {1'b0, a} - {1'b0, b};
        end else begin
            full = {1'b0, a} + {1'b0, b};
        end
        res = full[WIDTH-1:0];
        // a >= b when the subtraction does not borrow
        ge  = ~full[WIDTH];
    end

endmodule

// File: design/lrpt_seq.sv
`timescale 1ns / 1ps

module lrpt_seq #(
    parameter int TIME_BITS     = 24,
    parameter int PROGRESS_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // request side
    input  logic                       req_valid,
    output logic                       req_ready,
    input  logic [2:0]                 req_type,
    input  logic [15:0]                tick_delta,
    // configuration
    input  logic [TIME_BITS-1:0]       ramp_duration,
    input  logic [TIME_BITS-1:0]       start_delay,
    input  logic [16:0]                loop_limit,
    input  logic                       ping_pong_mode,
    // result side
    input  logic                       res_free,
    output logic                       res_valid,
    output logic [PROGRESS_BITS:0]     progress,
    output logic [1:0]                 run_state,
    output logic [15:0]                loops_done,
    output logic [TIME_BITS+1:0]       elapsed_time,
    output lrpt_pkg::evt_flags_t       flags
);

    localparam int EW = TIME_BITS + 2;
    localparam int AW = ((EW > lrpt_pkg::DELTA_W) ? EW : lrpt_pkg::DELTA_W) + 1;
    localparam int CW = $clog2(PROGRESS_BITS);
    localparam logic [PROGRESS_BITS:0] PROG_ONE = {1'b1, {PROGRESS_BITS{1'b0}}};
    localparam logic [EW-1:0] ELAPSED_MAX = {EW{1'b1}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_DLY_CHK,
        S_DLY_ADD,
        S_DLY_CMP,
        S_EL_ADD,
        S_END_CMP,
        S_RATIO,
        S_DIV,
        S_MIX,
        S_FIN
    } state_t;

    state_t                   state_reg, state_next;
    logic [1:0]               mode_reg, mode_next;
    logic [EW-1:0]            elapsed_reg, elapsed_next;
    logic [TIME_BITS-1:0]     delay_reg, delay_next;
    logic [PROGRESS_BITS:0]   progress_reg, progress_next;
    logic [15:0]              loops_reg, loops_next;
    logic                     rev_reg, rev_next;
    lrpt_pkg::evt_flags_t     flags_reg, flags_next;
    logic                     ended_reg, ended_next;
    logic [15:0]              dt_reg, dt_next;
    logic [AW-1:0]            wrk_reg, wrk_next;
    logic [PROGRESS_BITS:0]   quot_reg, quot_next;
    logic [CW-1:0]            cnt_reg, cnt_next;

    logic                     alu_op;
    logic [AW-1:0]            alu_a, alu_b, alu_res;
    logic                     alu_ge;
    logic                     dur_zero;
    logic [15:0]              loops_inc;
    logic                     limit_hit;

    lrpt_alu #(.WIDTH(AW)) u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res),
        .ge  (alu_ge)
    );

    assign dur_zero  = (ramp_duration == '0);
    assign loops_inc = (loops_reg == lrpt_pkg::LOOP_MAX) ? loops_reg : loops_reg + 16'd1;
    // only a positive limit can be hit; negative values loop forever, zero is handled apart
    assign limit_hit = !loop_limit[16] && (loop_limit != '0) && (loops_inc >= loop_limit[15:0]);

    // operand selection for the shared unit
    always_comb begin
        alu_op = lrpt_pkg::ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        case (state_reg)
            S_DLY_CHK: begin
                alu_op = lrpt_pkg::ALU_SUB;
                alu_a  = AW'(delay_reg);
                alu_b  = AW'(start_delay);
            end
            S_DLY_ADD: begin
                alu_a  = AW'(delay_reg);
                alu_b  = AW'(dt_reg);
            end
            S_DLY_CMP: begin
                alu_op = lrpt_pkg::ALU_SUB;
                alu_a  = wrk_reg;
                alu_b  = AW'(start_delay);
            end
            S_EL_ADD: begin
                alu_a  = AW'(elapsed_reg);
                alu_b  = AW'(dt_reg);
            end
            S_END_CMP, S_RATIO: begin
                alu_op = lrpt_pkg::ALU_SUB;
                alu_a  = AW'(elapsed_reg);
                alu_b  = AW'(ramp_duration);
            end
            S_DIV: begin
                alu_op = lrpt_pkg::ALU_SUB;
                alu_a  = {wrk_reg[AW-2:0], 1'b0};
                alu_b  = AW'(ramp_duration);
            end
            default: begin
                alu_op = lrpt_pkg::ALU_ADD;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        elapsed_next  = elapsed_reg;
        delay_next    = delay_reg;
        progress_next = progress_reg;
        loops_next    = loops_reg;
        rev_next      = rev_reg;
        flags_next    = flags_reg;
        ended_next    = ended_reg;
        dt_next       = dt_reg;
        wrk_next      = wrk_reg;
        quot_next     = quot_reg;
        cnt_next      = cnt_reg;

        case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    flags_next = '0;
                    ended_next = 1'b0;
                    dt_next    = tick_delta;
                    state_next = S_FIN;
                    case (req_type)
                        lrpt_pkg::REQ_START: begin
                            mode_next           = lrpt_pkg::MODE_RUN;
                            elapsed_next        = '0;
                            delay_next          = '0;
                            progress_next       = '0;
                            loops_next          = '0;
                            rev_next            = 1'b0;
                            flags_next.started  = 1'b1;
                        end
                        lrpt_pkg::REQ_STOP, lrpt_pkg::REQ_RESET: begin
                            mode_next     = lrpt_pkg::MODE_IDLE;
                            elapsed_next  = '0;
                            delay_next    = '0;
                            progress_next = '0;
                            loops_next    = '0;
                            rev_next      = 1'b0;
                        end
                        lrpt_pkg::REQ_PAUSE: begin
                            if (mode_reg == lrpt_pkg::MODE_RUN) begin
                                mode_next = lrpt_pkg::MODE_PAUSE;
                            end
                        end
                        lrpt_pkg::REQ_RESUME: begin
                            if (mode_reg == lrpt_pkg::MODE_PAUSE) begin
                                mode_next = lrpt_pkg::MODE_RUN;
                            end
                        end
                        lrpt_pkg::REQ_TICK: begin
                            if (mode_reg == lrpt_pkg::MODE_RUN) begin
                                state_next = S_DLY_CHK;
                            end
                        end
                        default: begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_DLY_CHK: begin
                state_next = alu_ge ? S_EL_ADD : S_DLY_ADD;
            end
            S_DLY_ADD: begin
                wrk_next   = alu_res;
                state_next = S_DLY_CMP;
            end
            S_DLY_CMP: begin
                if (alu_ge) begin
                    // delay used up, the remainder feeds the ramp
                    dt_next    = alu_res[15:0];
                    delay_next = start_delay;
                    state_next = S_EL_ADD;
                end else begin
                    delay_next = wrk_reg[TIME_BITS-1:0];
                    state_next = S_FIN;
                end
            end
            S_EL_ADD: begin
                if (alu_res[AW-1:EW] != '0) begin
                    elapsed_next = ELAPSED_MAX;
                end else begin
                    elapsed_next = alu_res[EW-1:0];
                end
                state_next = S_END_CMP;
            end
            S_END_CMP: begin
                if (!(dur_zero || alu_ge)) begin
                    wrk_next   = AW'(elapsed_reg);
                    quot_next  = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end else if (loop_limit == '0) begin
                    elapsed_next = EW'(ramp_duration);
                    quot_next    = PROG_ONE;
                    ended_next   = 1'b1;
                    state_next   = S_MIX;
                end else begin
                    flags_next.loop_ended = 1'b1;
                    loops_next            = loops_inc;
                    if (limit_hit) begin
                        elapsed_next = EW'(ramp_duration);
                        quot_next    = PROG_ONE;
                        ended_next   = 1'b1;
                        state_next   = S_MIX;
                    end else begin
                        rev_next     = rev_reg ^ ping_pong_mode;
                        elapsed_next = alu_res[EW-1:0];
                        state_next   = S_RATIO;
                    end
                end
            end
            S_RATIO: begin
                // overflow past a second duration clamps to full scale
                if (dur_zero || alu_ge) begin
                    quot_next  = PROG_ONE;
                    state_next = S_MIX;
                end else begin
                    wrk_next   = AW'(elapsed_reg);
                    quot_next  = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (alu_ge) begin
                    wrk_next  = alu_res;
                    quot_next = {quot_reg[PROGRESS_BITS-1:0], 1'b1};
                end else begin
                    wrk_next  = {wrk_reg[AW-2:0], 1'b0};
                    quot_next = {quot_reg[PROGRESS_BITS-1:0], 1'b0};
                end
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(PROGRESS_BITS - 1)) begin
                    state_next = S_MIX;
                end
            end
            S_MIX: begin
                progress_next = rev_reg ? (PROG_ONE - quot_reg) : quot_reg;
                if (ended_reg) begin
                    mode_next            = lrpt_pkg::MODE_DONE;
                    flags_next.completed = 1'b1;
                end
                state_next = S_FIN;
            end
            S_FIN: begin
                if (res_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            mode_reg     <= lrpt_pkg::MODE_IDLE;
            elapsed_reg  <= '0;
            delay_reg    <= '0;
            progress_reg <= '0;
            loops_reg    <= '0;
            rev_reg      <= 1'b0;
            flags_reg    <= '0;
            ended_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            elapsed_reg  <= elapsed_next;
            delay_reg    <= delay_next;
            progress_reg <= progress_next;
            loops_reg    <= loops_next;
            rev_reg      <= rev_next;
            flags_reg    <= flags_next;
            ended_reg    <= ended_next;
        end
        dt_reg   <= dt_next;
        wrk_reg  <= wrk_next;
        quot_reg <= quot_next;
        cnt_reg  <= cnt_next;
    end

    assign req_ready    = (state_reg == S_IDLE);
    assign res_valid    = (state_reg == S_FIN) && res_free;
    assign progress     = progress_reg;
    assign run_state    = mode_reg;
    assign loops_done   = loops_reg;
    assign elapsed_time = elapsed_reg;
    assign flags        = flags_reg;

endmodule

// File: design/looping_ramp_progress_timer.sv
`timescale 1ns / 1ps

// Looping ramp progress timer. Each accepted command (start, stop, pause,
// resume, reset, tick) gives exactly one result transfer carrying progress in
// Q1.PROGRESS_BITS, run state, loop count, elapsed time and event flags.
// Commands other than a running tick go straight to the hand-over state S_FIN,
// which loads the output register once it is free. A running tick uses one
// shared add/subtract/compare unit: S_DLY_CHK, S_DLY_ADD and S_DLY_CMP while
// start delay remains (the tick ends there if some is left), S_EL_ADD for the
// elapsed add, S_END_CMP for the loop-end compare, S_RATIO after a loop end,
// restoring division in S_DIV when progress is below full scale, and S_MIX and
// S_FIN to mix and hand over. A new command is taken only once the previous
// result is in the output register, which frees the input side while it waits;
// the hand-over stalls while the output register still holds an unsent result.
module looping_ramp_progress_timer #(
    parameter int TIME_BITS     = 24,
    parameter int PROGRESS_BITS = 16,
    localparam int CFG_W        = (TIME_BITS > 17) ? TIME_BITS : 17,
    localparam int OUT_W        = PROGRESS_BITS + TIME_BITS + 24,
    localparam int M_TDATA_W    = ((OUT_W + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration writes
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // tick_delta
    input  logic [2:0]            s_tuser,   // req_type
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // progress, run_state, loops_done, elapsed_time, loop_ended, completed,
    // started, zero fill
    output logic [M_TDATA_W-1:0]  m_tdata
);

    localparam logic [PROGRESS_BITS:0] PROG_ONE = {1'b1, {PROGRESS_BITS{1'b0}}};

    logic [TIME_BITS-1:0]   duration_reg;
    logic [TIME_BITS-1:0]   delay_cfg_reg;
    logic [16:0]            limit_reg;
    logic                   pingpong_reg;

    logic                   out_valid_reg;
    logic [PROGRESS_BITS:0] out_progress_reg;
    logic [1:0]             out_state_reg;
    logic [15:0]            out_loops_reg;
    logic [TIME_BITS+1:0]   out_elapsed_reg;
    lrpt_pkg::evt_flags_t   out_flags_reg;

    logic                   res_free;
    logic                   res_valid;
    logic [PROGRESS_BITS:0] res_progress;
    logic [1:0]             res_state;
    logic [15:0]            res_loops;
    logic [TIME_BITS+1:0]   res_elapsed;
    lrpt_pkg::evt_flags_t   res_flags;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duration_reg  <= lrpt_pkg::DURATION_RST[TIME_BITS-1:0];
            delay_cfg_reg <= '0;
            limit_reg     <= '0;
            pingpong_reg  <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                lrpt_pkg::CFG_DURATION: duration_reg  <= cfg_wdata[TIME_BITS-1:0];
                lrpt_pkg::CFG_DELAY:    delay_cfg_reg <= cfg_wdata[TIME_BITS-1:0];
                lrpt_pkg::CFG_LOOPS:    limit_reg     <= cfg_wdata[16:0];
                lrpt_pkg::CFG_PINGPONG: pingpong_reg  <= cfg_wdata[0];
                default:                pingpong_reg  <= pingpong_reg;
            endcase
        end
    end

    assign res_free = !out_valid_reg || m_tready;

    lrpt_seq #(
        .TIME_BITS     (TIME_BITS),
        .PROGRESS_BITS (PROGRESS_BITS)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .req_valid      (s_tvalid),
        .req_ready      (s_tready),
        .req_type       (s_tuser),
        .tick_delta     (s_tdata),
        .ramp_duration  (duration_reg),
        .start_delay    (delay_cfg_reg),
        .loop_limit     (limit_reg),
        .ping_pong_mode (pingpong_reg),
        .res_free       (res_free),
        .res_valid      (res_valid),
        .progress       (res_progress),
        .run_state      (res_state),
        .loops_done     (res_loops),
        .elapsed_time   (res_elapsed),
        .flags          (res_flags)
    );

    // output register, loaded only when the previous transfer has gone
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (res_valid) begin
            out_progress_reg <= res_progress;
            out_state_reg    <= res_state;
            out_loops_reg    <= res_loops;
            out_elapsed_reg  <= res_elapsed;
            out_flags_reg    <= res_flags;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_flags_reg.started, out_flags_reg.completed,
                                  out_flags_reg.loop_ended, out_elapsed_reg,
                                  out_loops_reg, out_state_reg, out_progress_reg});

    // one command at a time: the sequencer is busy right after a transfer in
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while a command is in progress");

    a_progress_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_progress_reg <= PROG_ONE))
        else $error("progress beyond full scale");

    a_completed_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_flags_reg.completed |->
            (out_state_reg == lrpt_pkg::MODE_DONE) && (out_progress_reg == PROG_ONE
            || out_progress_reg == '0))
        else $error("completion reported without finished state");

    a_start_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_flags_reg.started |->
            (out_state_reg == lrpt_pkg::MODE_RUN) && (out_progress_reg == '0)
            && (out_loops_reg == '0) && !out_flags_reg.loop_ended)
        else $error("start result does not show a cleared run");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int          PROG_BITS    = 16;
    localparam longint      PROG_ONE     = 64'd1 << PROG_BITS;
    localparam longint      ELAPSED_TOP  = (64'd1 << 26) - 1;
    localparam int unsigned LIMIT_CYCLES = 1_000_000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned SETTLE       = 4;
    localparam int unsigned TAIL_CYCLES  = 40;

    // codes the block must ignore
    localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
    localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

    localparam logic [16:0] LIMIT_ENDLESS = 17'h1FFFF;
    localparam logic [16:0] LIMIT_LOWEST  = 17'h10000;
    localparam logic [16:0] LIMIT_TOP     = 17'h0FFFF;

    // same layout as m_tdata, lowest field last
    typedef struct packed {
        logic        started;
        logic        completed;
        logic        loop_ended;
        logic [25:0] elapsed;
        logic [15:0] loops;
        logic [1:0]  run_state;
        logic [16:0] progress;
    } ramp_out_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = lrpt_pkg::CFG_DURATION;
    logic [23:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;   // tick_delta
    logic [2:0]  s_tuser   = lrpt_pkg::REQ_TICK;   // req_type
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    // progress, run_state, loops_done, elapsed_time, loop_ended, completed, started
    logic [63:0] m_tdata;

    looping_ramp_progress_timer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // register copies
    logic [23:0]        duration_cfg = 24'd1000000;
    logic [23:0]        delay_cfg    = '0;
    logic signed [16:0] limit_cfg    = '0;
    logic               pingpong_cfg = 1'b0;

    // ramp state
    logic [1:0]  mode_q     = lrpt_pkg::MODE_IDLE;
    logic [25:0] elapsed_q  = '0;
    logic [23:0] delay_q    = '0;
    logic [16:0] progress_q = '0;
    logic [15:0] loops_q    = '0;
    logic        reversed_q = 1'b0;

    ramp_out_t   ramp_expected_q[$];

    int unsigned errors        = 0;
    int unsigned cmds_sent     = 0;
    int unsigned results_seen  = 0;
    int unsigned settings_used = 0;
    int unsigned loop_ends     = 0;
    int unsigned completions   = 0;
    int unsigned cycle_count   = 0;

    bit          tx_steady = 1'b0;
    bit          tx_live   = 1'b0;
    logic        rx_steady = 1'b0;
    int unsigned hold_tag  = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    function automatic void clear_run(input logic [1:0] mode);
        mode_q     = mode;
        elapsed_q  = '0;
        delay_q    = '0;
        progress_q = '0;
        loops_q    = '0;
        reversed_q = 1'b0;
    endfunction

    function automatic longint unsigned q16_ratio(input longint unsigned el);
        if (duration_cfg == 0) return PROG_ONE;
        return (el << PROG_BITS) / duration_cfg;
    endfunction

    function automatic ramp_out_t advance_ramp(input logic [2:0] req, input logic [15:0] delta);
        ramp_out_t         r;
        longint unsigned   dt;
        longint unsigned   d;
        longint unsigned   el;
        longint unsigned   raw;
        bit                go;
        bit                ended;
        r  = '0;
        dt = 64'(delta);
        case (req)
            lrpt_pkg::REQ_START: begin
                clear_run(lrpt_pkg::MODE_RUN);
                r.started = 1'b1;
            end
            lrpt_pkg::REQ_STOP, lrpt_pkg::REQ_RESET: begin
                clear_run(lrpt_pkg::MODE_IDLE);
            end
            lrpt_pkg::REQ_PAUSE: begin
                if (mode_q == lrpt_pkg::MODE_RUN) mode_q = lrpt_pkg::MODE_PAUSE;
            end
            lrpt_pkg::REQ_RESUME: begin
                if (mode_q == lrpt_pkg::MODE_PAUSE) mode_q = lrpt_pkg::MODE_RUN;
            end
            lrpt_pkg::REQ_TICK: begin
                if (mode_q == lrpt_pkg::MODE_RUN) begin
                    go = 1'b1;
                    // start delay first, remainder carries into the ramp
                    if (delay_q < delay_cfg) begin
                        d = delay_q + dt;
                        if (d < delay_cfg) begin
                            delay_q = d[23:0];
                            go = 1'b0;
                        end else begin
                            dt = d - delay_cfg;
                            delay_q = delay_cfg;
                        end
                    end
                    if (go) begin
                        el = elapsed_q + dt;
                        if (el > ELAPSED_TOP) el = ELAPSED_TOP;
                        ended = (duration_cfg == 0) || (el >= duration_cfg);
                        raw = q16_ratio(el);
                        if (ended) begin
                            if (limit_cfg != 0) begin
                                r.loop_ended = 1'b1;
                                if (loops_q != lrpt_pkg::LOOP_MAX) loops_q = loops_q + 16'd1;
                                if (limit_cfg > 0 && int'(loops_q) >= int'(limit_cfg)) begin
                                    el  = 64'(duration_cfg);
                                    raw = PROG_ONE;
                                end else begin
                                    if (pingpong_cfg) reversed_q = ~reversed_q;
                                    el    = el - duration_cfg;
                                    raw   = q16_ratio(el);
                                    ended = 1'b0;
                                end
                            end else begin
                                raw = PROG_ONE;
                                el  = 64'(duration_cfg);
                            end
                        end
                        if (raw > PROG_ONE) raw = PROG_ONE;
                        if (reversed_q) raw = PROG_ONE - raw;
                        progress_q = raw[16:0];
                        elapsed_q  = el[25:0];
                        if (ended) begin
                            mode_q      = lrpt_pkg::MODE_DONE;
                            r.completed = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.progress  = progress_q;
        r.run_state = mode_q;
        r.loops     = loops_q;
        r.elapsed   = elapsed_q;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        errors++;
        if (errors <= 30)
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    always @(posedge aclk) begin : result_check
        ramp_out_t got;
        ramp_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            results_seen++;
            if (ramp_expected_q.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, 64'd0);
            end else begin
                want = ramp_expected_q.pop_front();
                if (got.progress !== want.progress)
                    report_mismatch("progress", 64'(got.progress), 64'(want.progress));
                if (got.run_state !== want.run_state)
                    report_mismatch("run_state", 64'(got.run_state), 64'(want.run_state));
                if (got.loops !== want.loops)
                    report_mismatch("loops_done", 64'(got.loops), 64'(want.loops));
                if (got.elapsed !== want.elapsed)
                    report_mismatch("elapsed_time", 64'(got.elapsed), 64'(want.elapsed));
                if (got.loop_ended !== want.loop_ended)
                    report_mismatch("loop_ended", 64'(got.loop_ended), 64'(want.loop_ended));
                if (got.completed !== want.completed)
                    report_mismatch("completed", 64'(got.completed), 64'(want.completed));
                if (got.started !== want.started)
                    report_mismatch("started", 64'(got.started), 64'(want.started));
            end
        end
    end

    // receiver: random stalls, steady stretches, and a long hold-off on request
    always @(posedge aclk) begin
        if (hold_seen != hold_tag) begin
            hold_seen <= hold_tag;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (rx_steady) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= 35);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, ramp_expected_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_req(input logic [2:0] req, input logic [15:0] delta);
        while (!tx_steady && $urandom_range(0, 99) < 35) begin
            if (tx_live) s_tvalid <= 1'b0;
            tx_live = 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= delta;
        tx_live = 1'b1;
        do @(posedge aclk); while (!s_tready);
        ramp_expected_q.push_back(advance_ramp(req, delta));
        if (ramp_expected_q[$].loop_ended) loop_ends++;
        if (ramp_expected_q[$].completed) completions++;
        cmds_sent++;
    endtask

    task automatic wait_drained();
        if (tx_live) s_tvalid <= 1'b0;
        tx_live = 1'b0;
        while (ramp_expected_q.size() != 0) @(posedge aclk);
    endtask

    task automatic cfg_put(input logic [1:0] idx, input logic [23:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic load_config(input logic [23:0] dur, input logic [23:0] dly,
                               input logic [16:0] lim, input logic pp);
        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        cfg_put(lrpt_pkg::CFG_DURATION, dur);
        cfg_put(lrpt_pkg::CFG_DELAY, dly);
        cfg_put(lrpt_pkg::CFG_LOOPS, {7'd0, lim});
        cfg_put(lrpt_pkg::CFG_PINGPONG, {23'd0, pp});
        cfg_we <= 1'b0;
        duration_cfg = dur;
        delay_cfg    = dly;
        limit_cfg    = lim;
        pingpong_cfg = pp;
        settings_used++;
    endtask

    function automatic logic [15:0] pick_delta();
        longint unsigned span;
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return 16'h0000;
            2: return 16'hFFFF;
            default: begin
                span = (duration_cfg == 0) ? 64'd64 : 64'(duration_cfg / 3 + 1);
                if (span > 65535) span = 65535;
                return 16'($urandom_range(0, int'(span)));
            end
        endcase
    endfunction

    function automatic logic [2:0] pick_req();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        // lean towards sequences that keep the ramp running
        if (mode_q == lrpt_pkg::MODE_PAUSE && roll < 50) return lrpt_pkg::REQ_RESUME;
        if ((mode_q == lrpt_pkg::MODE_IDLE || mode_q == lrpt_pkg::MODE_DONE) && roll < 40)
            return lrpt_pkg::REQ_START;
        if (roll < 2) return REQ_UNUSED_LO;
        if (roll < 4) return REQ_UNUSED_HI;
        if (roll < 6) return lrpt_pkg::REQ_STOP;
        if (roll < 8) return lrpt_pkg::REQ_RESET;
        if (roll < 13) return lrpt_pkg::REQ_PAUSE;
        if (roll < 17) return lrpt_pkg::REQ_RESUME;
        if (roll < 21) return lrpt_pkg::REQ_START;
        return lrpt_pkg::REQ_TICK;
    endfunction

    task automatic random_config();
        logic [23:0] dur;
        logic [23:0] dly;
        logic [16:0] lim;
        case ($urandom_range(0, 9))
            0:       dur = '0;
            1:       dur = 24'($urandom);
            2:       dur = 24'hFFFFFF;
            default: dur = 24'($urandom_range(1, 3000));
        endcase
        case ($urandom_range(0, 5))
            0:       dly = 24'($urandom);
            1, 2:    dly = '0;
            default: dly = 24'($urandom_range(0, 2000));
        endcase
        case ($urandom_range(0, 7))
            0:       lim = LIMIT_ENDLESS;
            1:       lim = '0;
            2:       lim = 17'($urandom);
            3:       lim = LIMIT_LOWEST | 17'($urandom_range(0, 65533));
            default: lim = 17'($urandom_range(1, 6));
        endcase
        load_config(dur, dly, lim, 1'($urandom));
    endtask

    task automatic run_random_phase(input int unsigned n_items);
        send_req(lrpt_pkg::REQ_START, pick_delta());
        repeat (n_items) send_req(pick_req(), pick_delta());
    endtask

    // register reset values, commands in the wrong state, unused codes
    task automatic test_reset_state();
        send_req(lrpt_pkg::REQ_TICK, 16'd500);
        send_req(lrpt_pkg::REQ_PAUSE, 16'd0);
        send_req(lrpt_pkg::REQ_RESUME, 16'd0);
        send_req(REQ_UNUSED_LO, 16'hFFFF);
        send_req(REQ_UNUSED_HI, 16'h5A5A);
        send_req(lrpt_pkg::REQ_START, 16'h1234);
        send_req(lrpt_pkg::REQ_TICK, 16'd0);
        send_req(lrpt_pkg::REQ_TICK, 16'hFFFF);
        send_req(lrpt_pkg::REQ_PAUSE, 16'd0);
        send_req(lrpt_pkg::REQ_TICK, 16'd100);
        send_req(lrpt_pkg::REQ_RESUME, 16'd0);
        send_req(lrpt_pkg::REQ_RESET, 16'd0);
    endtask

    task automatic test_zero_duration();
        load_config(24'd0, 24'd0, 17'd0, 1'b0);
        send_req(lrpt_pkg::REQ_START, 16'd0);
        send_req(lrpt_pkg::REQ_TICK, 16'd1);
        send_req(lrpt_pkg::REQ_TICK, 16'd1);
    endtask

    // delay carry-over, loop end with overflow, reversal, finite limit reached
    task automatic test_delay_and_ping_pong();
        load_config(24'd100, 24'd50, 17'd2, 1'b1);
        send_req(lrpt_pkg::REQ_START, 16'd0);
        send_req(lrpt_pkg::REQ_TICK, 16'd30);
        send_req(lrpt_pkg::REQ_TICK, 16'd40);
        send_req(lrpt_pkg::REQ_TICK, 16'd100);
        send_req(lrpt_pkg::REQ_TICK, 16'hFFFF);
        send_req(lrpt_pkg::REQ_STOP, 16'd0);
    endtask

    task automatic test_wide_settings();
        load_config(24'hFFFFFF, 24'hFFFFFF, LIMIT_LOWEST, 1'b1);
        send_req(lrpt_pkg::REQ_START, 16'd0);
        send_req(lrpt_pkg::REQ_TICK, 16'hFFFF);
    endtask

    task automatic test_back_pressure();
        load_config(24'd200, 24'd0, LIMIT_TOP, 1'b1);
        tx_steady = 1'b1;
        send_req(lrpt_pkg::REQ_START, 16'd0);
        hold_tag <= hold_tag + 1;
        repeat (40) send_req(lrpt_pkg::REQ_TICK, pick_delta());
        tx_steady = 1'b0;
        wait_drained();
    endtask

    task automatic test_pause_until_drained();
        load_config(24'd1000, 24'd100, LIMIT_ENDLESS, 1'b0);
        send_req(lrpt_pkg::REQ_START, 16'd0);
        repeat (10) send_req(lrpt_pkg::REQ_TICK, pick_delta());
        wait_drained();
        repeat (10) send_req(lrpt_pkg::REQ_TICK, pick_delta());
    endtask

    task automatic test_random_runs();
        repeat (24) begin
            random_config();
            run_random_phase(60);
        end
    endtask

    task automatic test_steady_stream();
        tx_steady = 1'b1;
        rx_steady <= 1'b1;
        repeat (6) begin
            random_config();
            run_random_phase(50);
        end
        wait_drained();
        tx_steady = 1'b0;
        rx_steady <= 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_zero_duration();
        test_delay_and_ping_pong();
        test_wide_settings();
        test_back_pressure();
        test_pause_until_drained();
        test_random_runs();
        test_steady_stream();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("sent %0d commands under %0d register settings plus reset values",
                 cmds_sent, settings_used);
        $display("checked %0d results: %0d loop ends, %0d completions, %0d mismatches",
                 results_seen, loop_ends, completions, errors);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/lrpt_pkg.sv
design/lrpt_alu.sv
design/lrpt_seq.sv
design/looping_ramp_progress_timer.sv
test/tb_top.sv
